// ===== rtl/edf_pkg.sv =====
// Shared types and constants for the EDF scheduler with frequency governor.
// No dependencies.
`timescale 1ns / 1ps
package edf_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam logic [15:0] PERF_THR_RESET = 16'd4000;
    localparam logic [2:0] LEVEL_MAX = 3'd4;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_FINISH   = 3'd1;
    localparam logic [2:0] EV_MISS     = 3'd2;
    localparam logic [2:0] EV_PREEMPT  = 3'd3;
    localparam logic [2:0] EV_DISPATCH = 3'd4;

    localparam logic [0:0] CFG_MODE = 1'b0;
    localparam logic [0:0] CFG_THR  = 1'b1;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] absdl;
        logic [14:0] act;
        logic [14:0] exec;
    } thr_t;
endpackage

// ===== rtl/edf_scheduler_with_dvfs.sv =====
// Top level of the EDF scheduler with a five-level frequency governor.
// Depends on edf_pkg. Ready queue held in one synchronous memory.
`timescale 1ns / 1ps
//
// Usage:
//   s_* channel: one beat per add or tick item. tuser holds kind; tdata holds
//     thread_id, relative deadline, activation tick, execution ticks.
//   m_* channel: one result beat per item.
//   cfg_*: register writes (index 0 governor_mode, index 1 IPS threshold),
//     taken only while the block is idle; a config beat wins over an item.
// Flow: a dropped add (queue full) goes straight to the result step. An add
//   reads and shifts entries up until it finds its place; moves is the number
//   of entries shifted up, one per read/write pair. A tick reads the head,
//   decides and updates the governor; a dispatch pops the head, and a
//   preemption pops and re-inserts. The next item is accepted only after
//   its result is loaded.
// Reset: aresetn low clears counters, the run record and the level; queue
//   entries stay undefined and only entries below the count are read.
// Stall: a finished result sits in the output register; the next item can
//   be accepted and runs up to its last step, where it waits for the slot.
//
module edf_scheduler_with_dvfs
    import edf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tuser: kind[0]
    input  logic [0:0]  s_tuser,
    // tdata: thread_id[7:0], relative_deadline[22:8],
    // activation tick[37:23], execution ticks[52:38], zero fill to 56
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: accepted[0], running_valid[1], running_id[9:2],
    // sched_event[12:10], freq_level[15:13], time_now[31:16]
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HEAD   = 4'd1;  // head read issued
    localparam logic [3:0] ST_DECIDE = 4'd2;
    localparam logic [3:0] ST_INS_RD = 4'd3;  // read pos-1
    localparam logic [3:0] ST_INS_CK = 4'd4;
    localparam logic [3:0] ST_POP_RD = 4'd5;
    localparam logic [3:0] ST_POP_WR = 4'd6;
    localparam logic [3:0] ST_GOV_RD = 4'd7;
    localparam logic [3:0] ST_GOV    = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    thr_t mem [QUEUE_DEPTH];
    thr_t rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    thr_t          wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          run_valid_reg, run_valid_next;
    thr_t          run_reg, run_next;
    logic [14:0]   exec_cnt_reg, exec_cnt_next;
    logic [15:0]   tick_reg, tick_next;
    logic [15:0]   idle_reg, idle_next;
    logic [2:0]    level_reg, level_next;
    logic          mode_reg;
    logic [15:0]   thr_reg;
    thr_t          ins_reg, ins_next;     // record being inserted
    thr_t          head_reg, head_next;   // popped head
    logic          kind_reg, kind_next;
    logic          acc_reg, acc_next;
    logic [2:0]    ev_reg, ev_next;
    logic          after_pop_reg, after_pop_next; // insert follows a pop
    logic          mvalid_reg, mvalid_next;
    logic [31:0]   mdata_reg, mdata_next;

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

    wire s_fire = s_tvalid && s_tready;
    wire out_free = !mvalid_reg || m_tready;  // result slot free at this edge

    // governor usage terms (19-bit products)
    logic [15:0] busy;
    logic [18:0] busy5, t4, t2;
    logic        above80, below80, below40;
    logic signed [17:0] slack;
    logic        slack_inf;
    logic [15:0] ips;

    always_comb begin
        busy    = (idle_reg > tick_reg) ? 16'd0 : tick_reg - idle_reg;
        busy5   = {3'd0, busy} + {1'b0, busy, 2'b00};
        t4      = {1'b0, tick_reg, 2'b00};
        t2      = {2'b0, tick_reg, 1'b0};
        above80 = (tick_reg != 16'd0) && (busy5 > t4);
        below80 = (tick_reg == 16'd0) || (busy5 < t4);
        below40 = (tick_reg == 16'd0) || (busy5 < t2);
        slack_inf = 1'b0;
        slack     = '0;
        if (run_valid_reg)
            slack = $signed({2'b0, run_reg.absdl}) - $signed({2'b0, tick_reg});
        else if (count_reg != '0)
            slack = $signed({2'b0, rd_data_reg.absdl}) - $signed({2'b0, tick_reg});
        else
            slack_inf = 1'b1;
        ips = 16'd5000 + 16'(level_reg) * 16'd1250;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        exec_cnt_next  = exec_cnt_reg;
        tick_next      = tick_reg;
        idle_next      = idle_reg;
        level_next     = level_reg;
        ins_next       = ins_reg;
        head_next      = head_reg;
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        ev_next        = ev_reg;
        after_pop_next = after_pop_reg;
        mvalid_next    = mvalid_reg;
        mdata_next     = mdata_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = ins_reg;

        if (mvalid_reg && m_tready) mvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next = s_tuser[0];
                    ins_next.id    = s_tdata[7:0];
                    ins_next.act   = s_tdata[37:23];
                    ins_next.absdl = {1'b0, s_tdata[37:23]} + {1'b0, s_tdata[22:8]};
                    ins_next.exec  = s_tdata[52:38];
                    acc_next = 1'b1;
                    ev_next  = EV_NONE;
                    after_pop_next = 1'b0;
                    rd_en    = 1'b1;
                    rd_addr  = '0;
                    if (s_tuser[0] == KIND_ADD) begin
                        if (count_reg >= DEPTH_C) begin
                            acc_next   = 1'b0;
                            state_next = ST_OUT;
                        end else begin
                            pos_next   = count_reg;
                            state_next = ST_INS_RD;
                        end
                    end else begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD: state_next = ST_DECIDE;
            ST_DECIDE: begin
                state_next = ST_GOV_RD;
                if (run_valid_reg) begin
                    if (exec_cnt_reg >= run_reg.exec) begin
                        run_valid_next = 1'b0;
                        ev_next = EV_FINISH;
                    end else if (run_reg.absdl <= tick_reg) begin
                        run_valid_next = 1'b0;
                        ev_next = EV_MISS;
                    end else if (count_reg != '0 && rd_data_reg.absdl < run_reg.absdl
                                 && {1'b0, rd_data_reg.act} <= tick_reg) begin
                        ev_next   = EV_PREEMPT;
                        head_next = rd_data_reg;
                        ins_next  = run_reg;
                        ins_next.exec = run_reg.exec - exec_cnt_reg;
                        after_pop_next = 1'b1;
                        pos_next   = CW'(1);
                        state_next = ST_POP_RD;
                    end
                end else if (count_reg != '0 && {1'b0, rd_data_reg.act} <= tick_reg) begin
                    ev_next   = EV_DISPATCH;
                    head_next = rd_data_reg;
                    pos_next  = CW'(1);
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                // shift entry pos down to pos-1
                if (pos_reg >= count_reg) begin
                    count_next = count_reg - CW'(1);
                    run_next = head_reg;
                    run_valid_next = 1'b1;
                    exec_cnt_next = '0;
                    if (after_pop_reg) begin
                        pos_next   = count_reg - CW'(1);
                        state_next = ST_INS_RD;
                    end else begin
                        state_next = ST_GOV_RD;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = pos_reg[AW-1:0];
                    state_next = ST_POP_WR;
                end
            end
            ST_POP_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg - CW'(1));
                wr_data = rd_data_reg;
                pos_next = pos_reg + CW'(1);
                state_next = ST_POP_RD;
            end
            ST_INS_RD: begin
                if (pos_reg == '0) begin
                    wr_en = 1'b1;
                    wr_addr = '0;
                    count_next = count_reg + CW'(1);
                    state_next = (kind_reg == KIND_ADD) ? ST_OUT : ST_GOV_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(pos_reg - CW'(1));
                    state_next = ST_INS_CK;
                end
            end
            ST_INS_CK: begin
                wr_en = 1'b1;
                wr_addr = pos_reg[AW-1:0];
                if (rd_data_reg.absdl > ins_reg.absdl) begin
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg - CW'(1);
                    state_next = ST_INS_RD;
                end else begin
                    count_next = count_reg + CW'(1);
                    state_next = (kind_reg == KIND_ADD) ? ST_OUT : ST_GOV_RD;
                end
            end
            ST_GOV_RD: begin
                rd_en = 1'b1;
                rd_addr = '0;
                state_next = ST_GOV;
            end
            ST_GOV: begin
                // hold here until the result slot is free
                if (out_free) begin
                    if (!mode_reg) begin
                        if (above80 || (!slack_inf && slack < 18'sd5)) begin
                            if (level_reg < LEVEL_MAX) level_next = level_reg + 3'd1;
                        end else if (below80 && (slack_inf || slack > 18'sd5)) begin
                            if (level_reg != 3'd0) level_next = level_reg - 3'd1;
                        end
                    end else begin
                        if (ips < thr_reg) begin
                            if (level_reg < LEVEL_MAX) level_next = level_reg + 3'd1;
                        end else if (below40 && ips > thr_reg) begin
                            if (level_reg != 3'd0) level_next = level_reg - 3'd1;
                        end
                    end
                    if (run_valid_reg) begin
                        if (exec_cnt_reg != 15'h7FFF) exec_cnt_next = exec_cnt_reg + 15'd1;
                    end else if (idle_reg != 16'hFFFF) begin
                        idle_next = idle_reg + 16'd1;
                    end
                    if (tick_reg != 16'hFFFF) tick_next = tick_reg + 16'd1;
                    mdata_next = {tick_reg, level_next, ev_reg,
                                  run_valid_reg ? run_reg.id : 8'd0, run_valid_reg, acc_reg};
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    mdata_next = {tick_reg, level_reg, ev_reg,
                                  run_valid_reg ? run_reg.id : 8'd0, run_valid_reg, acc_reg};
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // mode write reloads the level; only taken while idle
        if (cfg_valid && cfg_ready && cfg_index == CFG_MODE)
            level_next = cfg_data[0] ? LEVEL_MAX : 3'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_reg       <= '0;
            exec_cnt_reg  <= '0;
            tick_reg      <= '0;
            idle_reg      <= '0;
            level_reg     <= '0;
            mode_reg      <= 1'b0;
            thr_reg       <= PERF_THR_RESET;
            mvalid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_reg       <= run_next;
            exec_cnt_reg  <= exec_cnt_next;
            tick_reg      <= tick_next;
            idle_reg      <= idle_next;
            level_reg     <= level_next;
            mvalid_reg    <= mvalid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MODE) begin
                    mode_reg  <= cfg_data[0];
                end else if (cfg_index == CFG_THR) begin
                    thr_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        ins_reg       <= ins_next;
        head_reg      <= head_next;
        kind_reg      <= kind_next;
        acc_reg       <= acc_next;
        ev_reg        <= ev_next;
        after_pop_reg <= after_pop_next;
        mdata_reg     <= mdata_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C) else $error("queue count above depth");
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_MAX) else $error("level out of range");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready) else $error("accept while busy");
    a_tick_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> tick_reg >= $past(tick_reg)) else $error("time went back");
`endif
endmodule

// ===== dv/edf_sched_checker.sv =====
// Checker for the EDF scheduler: watches config, input and result channels,
// predicts each result beat and compares it field by field. Depends on edf_pkg.
`timescale 1ns / 1ps
module edf_sched_checker
    import edf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [0:0]  s_tuser,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    thr_t        rq[QUEUE_DEPTH];
    int          qn;
    logic        rv;
    thr_t        rrec;
    logic [14:0] rexec;
    logic [15:0] ticks;
    logic [15:0] idles;
    logic [2:0]  lvl;
    logic        gmode;
    logic [15:0] thr;
    logic [31:0] sched_results[$];

    assign pending = sched_results.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void q_put(input thr_t t);
        int p;
        p = qn;
        while (p > 0 && rq[p-1].absdl > t.absdl) begin
            rq[p] = rq[p-1];
            p--;
        end
        rq[p] = t;
        qn++;
    endfunction

    function automatic thr_t q_take();
        thr_t h;
        h = rq[0];
        for (int i = 0; i < qn - 1; i++) rq[i] = rq[i+1];
        qn--;
        return h;
    endfunction

    function automatic void govern(input logic [15:0] t);
        longint busy, tt, slack;
        logic up, dn, a80, b80, b40, inf;
        int ips;
        busy = (idles > t) ? 0 : longint'(t) - longint'(idles);
        tt = longint'(t);
        a80 = (t > 0) && (5*busy > 4*tt);
        b80 = (t == 0) || (5*busy < 4*tt);
        b40 = (t == 0) || (5*busy < 2*tt);
        inf = 1'b0;
        slack = 0;
        up = 1'b0;
        dn = 1'b0;
        if (!gmode) begin
            if (rv) slack = longint'(rrec.absdl) - tt;
            else if (qn > 0) slack = longint'(rq[0].absdl) - tt;
            else inf = 1'b1;
            if (a80 || (!inf && slack < 5)) up = 1'b1;
            else if (b80 && (inf || slack > 5)) dn = 1'b1;
        end else begin
            ips = 5000 + 1250 * int'(lvl);
            if (ips < int'(thr)) up = 1'b1;
            else if (b40 && ips > int'(thr)) dn = 1'b1;
        end
        if (up && lvl < LEVEL_MAX) lvl++;
        else if (dn && lvl > 0) lvl--;
    endfunction

    function automatic logic [31:0] sched_step(input logic u, input logic [55:0] d);
        logic        acc;
        logic [2:0]  ev;
        logic [15:0] now;
        thr_t        t, nx, bk;
        acc = 1'b1;
        ev = EV_NONE;
        now = ticks;
        if (u == KIND_ADD) begin
            t.id = d[7:0];
            t.act = d[37:23];
            t.absdl = {1'b0, d[37:23]} + {1'b0, d[22:8]};
            t.exec = d[52:38];
            if (qn >= QUEUE_DEPTH) acc = 1'b0;
            else q_put(t);
        end else begin
            if (rv) begin
                if (rexec >= rrec.exec) begin
                    rv = 1'b0;
                    ev = EV_FINISH;
                end else if (rrec.absdl <= now) begin
                    rv = 1'b0;
                    ev = EV_MISS;
                end else if (qn > 0 && rq[0].absdl < rrec.absdl && rq[0].act <= now) begin
                    nx = q_take();
                    bk = rrec;
                    bk.exec = rrec.exec - rexec;
                    q_put(bk);
                    rrec = nx;
                    rexec = '0;
                    ev = EV_PREEMPT;
                end
            end else if (qn > 0 && rq[0].act <= now) begin
                rrec = q_take();
                rv = 1'b1;
                rexec = '0;
                ev = EV_DISPATCH;
            end
            govern(now);
            if (rv) begin
                if (rexec != 15'h7FFF) rexec++;
            end else if (idles != 16'hFFFF) idles++;
            if (ticks != 16'hFFFF) ticks++;
        end
        return {now, lvl, ev, (rv ? rrec.id : 8'd0), rv, acc};
    endfunction

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            qn = 0;
            rv = 1'b0;
            rrec = '0;
            rexec = '0;
            ticks = '0;
            idles = '0;
            lvl = '0;
            gmode = 1'b0;
            thr = PERF_THR_RESET;
            fail_count = 0;
            sched_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MODE) begin
                    gmode = cfg_data[0];
                    lvl = gmode ? LEVEL_MAX : 3'd0;
                end else thr = cfg_data;
            end
            if (s_tvalid && s_tready)
                sched_results.insert(sched_results.size(), sched_step(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready) begin
                if (sched_results.size() == 0) report("unexpected beat", m_tdata, 32'd0);
                else begin
                    want = sched_results.pop_front();
                    if (m_tdata[0] !== want[0])
                        report("accepted", 32'(m_tdata[0]), 32'(want[0]));
                    if (m_tdata[1] !== want[1])
                        report("running_valid", 32'(m_tdata[1]), 32'(want[1]));
                    if (m_tdata[9:2] !== want[9:2])
                        report("running_id", 32'(m_tdata[9:2]), 32'(want[9:2]));
                    if (m_tdata[12:10] !== want[12:10])
                        report("sched_event", 32'(m_tdata[12:10]), 32'(want[12:10]));
                    if (m_tdata[15:13] !== want[15:13])
                        report("freq_level", 32'(m_tdata[15:13]), 32'(want[15:13]));
                    if (m_tdata[31:16] !== want[31:16])
                        report("time_now", 32'(m_tdata[31:16]), 32'(want[31:16]));
                end
            end
        end
    end
endmodule

// ===== dv/edf_scheduler_with_dvfs_tb.sv =====
// Testbench top for edf_scheduler_with_dvfs: drives add/tick beats and register
// writes, random idling on both sides. Depends on edf_pkg and edf_sched_checker.
`timescale 1ns / 1ps
module edf_scheduler_with_dvfs_tb;
    import edf_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [0:0]  s_tuser;   // kind
    logic [55:0] s_tdata;   // thread_id, rel deadline, activation, exec
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // accepted, run valid, run id, event, level, time
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    bit          calm;      // no idling on either side when set

    edf_scheduler_with_dvfs uut (.*);
    edf_sched_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop; the worst case run is well under this.
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // Result side back-pressure, about 6 percent of the time, none while calm.
    always @(posedge aclk) m_tready <= calm || ($urandom_range(99) >= 6);

    // valid stays up after the beat; drain() drops it
    task automatic send_beat(input logic u, input logic [55:0] d);
        while (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= u;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [55:0] add_beat(input logic [7:0] id, input logic [14:0] rel,
                                             input logic [14:0] act, input logic [14:0] ex);
        return {3'b0, ex, act, rel, id};
    endfunction

    function automatic logic [55:0] tick_beat();
        logic [55:0] d;
        d = 56'({$urandom, $urandom});
        return d;
    endfunction

    // Wait for all results, plus a margin for the block to settle.
    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // Random phase: mostly short-deadline, small-exec threads plus ticks;
    // occasional extreme fields so every bit toggles.
    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            calm = (i >= n / 3 && i < n / 2);
            if ($urandom_range(99) < 55) send_beat(KIND_TICK, tick_beat());
            else if ($urandom_range(9) == 0)
                send_beat(KIND_ADD, add_beat(8'($urandom), 15'($urandom), 15'($urandom),
                                             15'($urandom)));
            else
                send_beat(KIND_ADD, add_beat(8'($urandom), 15'($urandom_range(40)),
                                             15'($urandom_range(60)),
                                             15'($urandom_range(6))));
        end
        calm = 0;
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tuser = KIND_ADD;
        s_tdata = '0;
        cfg_valid = 0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        calm = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty tick, zero exec, extremes, ties, preemption, queue full.
        send_beat(KIND_TICK, tick_beat());
        send_beat(KIND_ADD, add_beat(8'd1, 15'd10, 15'd0, 15'd0));
        send_beat(KIND_ADD, add_beat(8'd2, 15'd10, 15'd0, 15'd3));
        send_beat(KIND_ADD, add_beat(8'hFF, 15'h7FFF, 15'h7FFF, 15'h7FFF));
        repeat (3) send_beat(KIND_TICK, tick_beat());
        send_beat(KIND_ADD, add_beat(8'd3, 15'd1, 15'd0, 15'd2));
        repeat (3) send_beat(KIND_TICK, tick_beat());
        for (int i = 0; i < 17; i++)
            send_beat(KIND_ADD, add_beat(8'(i), 15'd100, 15'd50, 15'd1));
        repeat (2) send_beat(KIND_TICK, tick_beat());
        drain();

        write_reg(CFG_THR, 16'hFFFF);
        write_reg(CFG_MODE, 16'd1);
        random_phase(350);
        drain();
        write_reg(CFG_THR, 16'd0);
        random_phase(350);
        drain();
        write_reg(CFG_MODE, 16'd0);
        write_reg(CFG_THR, 16'd7500);
        random_phase(350);
        drain();
        write_reg(CFG_MODE, 16'd1);
        random_phase(330);
        drain();

        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/edf_pkg.sv
rtl/edf_scheduler_with_dvfs.sv
dv/edf_sched_checker.sv
dv/edf_scheduler_with_dvfs_tb.sv
